### hdl/rfp_pkg.sv
// Shared types, codes and constants of the RESP frame parser.
`default_nettype none
package rfp_pkg;

  localparam int LENGTH_BITS    = 30;
  localparam int COUNT_BITS     = 21;
  localparam int INDEX_BITS     = 20;
  localparam int VALUE_BITS     = 64;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_BULK  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_COUNT = CFG_INDEX_BITS'(1);

  localparam logic [LENGTH_BITS-1:0] MAX_BULK_RESET  = LENGTH_BITS'(64'd536870912);
  localparam logic [COUNT_BITS-1:0]  MAX_COUNT_RESET = COUNT_BITS'(64'd1048576);

  localparam logic [2:0] FT_SIMPLE  = 3'd0;
  localparam logic [2:0] FT_ERROR   = 3'd1;
  localparam logic [2:0] FT_INTEGER = 3'd2;
  localparam logic [2:0] FT_BULK    = 3'd3;
  localparam logic [2:0] FT_NULL    = 3'd4;
  localparam logic [2:0] FT_ARRAY   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_INT   = 3'd3;
  localparam logic [2:0] ST_BAD_TERM  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_TOO_LONG  = 3'd6;

  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // largest accumulator that can still take one more digit without leaving signed 64-bit range
  localparam logic [VALUE_BITS-1:0] INT_EDGE = 64'd922337203685477580;

  typedef enum logic [3:0] {
    PH_TYPE, PH_LINE, PH_LINE_LF, PH_INT, PH_INT_LF, PH_LEN, PH_LEN_LF,
    PH_DATA, PH_TRAIL_CR, PH_TRAIL_LF, PH_CNT, PH_CNT_LF, PH_ELEM, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_plus;
    logic       is_minus;
    logic       is_colon;
    logic       is_dollar;
    logic       is_star;
  } byte_class_t;

  typedef struct packed {
    logic                         payload_valid;
    logic [7:0]                   payload_byte;
    logic [INDEX_BITS-1:0]        element_index;
    logic                         element_done;
    logic                         frame_done;
    logic [2:0]                   frame_type;
    logic [2:0]                   frame_status;
    logic signed [VALUE_BITS-1:0] integer_value;
    logic [COUNT_BITS-1:0]        array_count;
  } result_t;

endpackage
`default_nettype wire

### hdl/rfp_if.sv
// Channel interfaces of the RESP frame parser: byte input and result output.
`default_nettype none
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface rfp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  payload_valid;
  logic [7:0]                            payload_byte;
  logic [rfp_pkg::INDEX_BITS-1:0]        element_index;
  logic                                  element_done;
  logic                                  frame_done;
  logic [2:0]                            frame_type;
  logic [2:0]                            frame_status;
  logic signed [rfp_pkg::VALUE_BITS-1:0] integer_value;
  logic [rfp_pkg::COUNT_BITS-1:0]        array_count;
  modport source (output valid, payload_valid, payload_byte, element_index, element_done,
                  frame_done, frame_type, frame_status, integer_value, array_count,
                  input ready);
  modport sink (input valid, payload_valid, payload_byte, element_index, element_done,
                frame_done, frame_type, frame_status, integer_value, array_count,
                output ready);
endinterface
`default_nettype wire

### hdl/rfp_front.sv
// Front stage: accept input bytes and classify them into a registered item.
`default_nettype none
module rfp_front (
  input  logic                 clk,
  input  logic                 rst,
  rfp_in_if.sink               in_ch,
  output rfp_pkg::byte_class_t cls,
  output logic                 cls_valid,
  input  logic                 cls_ready
);
  import rfp_pkg::*;

  byte_class_t cls_next;
  logic        take;

  assign in_ch.ready = !cls_valid || cls_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    cls_next.data      = in_ch.data_byte;
    cls_next.last      = in_ch.last_byte;
    cls_next.is_digit  = (in_ch.data_byte >= CH_ZERO) && (in_ch.data_byte <= CH_NINE);
    cls_next.digit     = in_ch.data_byte[3:0];
    cls_next.is_cr     = in_ch.data_byte == CH_CR;
    cls_next.is_lf     = in_ch.data_byte == CH_LF;
    cls_next.is_plus   = in_ch.data_byte == CH_PLUS;
    cls_next.is_minus  = in_ch.data_byte == CH_MINUS;
    cls_next.is_colon  = in_ch.data_byte == CH_COLON;
    cls_next.is_dollar = in_ch.data_byte == CH_DOLLAR;
    cls_next.is_star   = in_ch.data_byte == CH_STAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (take) begin
      cls_valid <= 1'b1;
    end else if (cls_ready) begin
      cls_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls <= cls_next;
    end
  end
endmodule
`default_nettype wire

### hdl/rfp_queue.sv
// Short FIFO of classified items between front and back.
`default_nettype none
module rfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  rfp_pkg::byte_class_t wr_item,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  output rfp_pkg::byte_class_t rd_item,
  output logic                 rd_valid,
  input  logic                 rd_ready
);
  import rfp_pkg::*;

  byte_class_t          slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;

  assign wr_ready = count != (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end
endmodule
`default_nettype wire

### hdl/rfp_back.sv
// Back stage: frame parser state machine and registered result.
`default_nettype none
module rfp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  rfp_pkg::byte_class_t              cls,
  input  logic                              cls_valid,
  output logic                              cls_ready,
  input  logic [rfp_pkg::LENGTH_BITS-1:0]   max_len,
  input  logic [rfp_pkg::COUNT_BITS-1:0]    max_cnt,
  rfp_out_if.source                         out_ch
);
  import rfp_pkg::*;

  phase_t                  phase;
  phase_t                  phase_adv;
  logic [2:0]              held, held_next;
  logic [VALUE_BITS-1:0]   acc, acc_next;
  logic                    neg, neg_next;
  logic                    dseen, dseen_next;
  logic                    istart, istart_next;
  logic [LENGTH_BITS-1:0]  bytes_rem, bytes_rem_next;
  logic [COUNT_BITS-1:0]   elem_rem, elem_rem_next;
  logic [INDEX_BITS-1:0]   cur_elem, cur_elem_next;
  logic [2:0]              sticky, sticky_next;
  logic [COUNT_BITS-1:0]   declared, declared_next;
  logic [2:0]              err;
  logic [2:0]              status;
  logic                    active;
  logic                    step;
  logic [VALUE_BITS-1:0]   lim;
  logic [VALUE_BITS-1:0]   ceil_val;
  logic [VALUE_BITS-1:0]   acc_mul;
  logic                    int_ovf;
  logic [2:0]              len_cr_err;
  phase_t                  fin_phase;
  result_t                 res;
  result_t                 res_q;
  logic                    out_valid;

  assign cls_ready = !out_valid || out_ch.ready;
  assign step      = cls_valid && cls_ready;
  assign active    = sticky == ST_OK;

  assign lim      = (phase == PH_CNT) ? VALUE_BITS'(max_cnt) : VALUE_BITS'(max_len);
  assign ceil_val = neg ? VALUE_BITS'(1) : lim;
  assign acc_mul  = {acc[VALUE_BITS-4:0], 3'b000} + {acc[VALUE_BITS-2:0], 1'b0}
                  + VALUE_BITS'(cls.digit);
  assign int_ovf  = (acc > INT_EDGE)
                  || ((acc == INT_EDGE) && (cls.digit > (neg ? 4'd8 : 4'd7)));
  assign fin_phase = ((held == FT_ARRAY) && (elem_rem != COUNT_BITS'(1))) ? PH_ELEM : PH_DONE;

  always_comb begin
    if (!dseen) begin
      len_cr_err = ST_BAD_LEN;
    end else if (neg && (acc != VALUE_BITS'(1))) begin
      len_cr_err = ST_BAD_LEN;
    end else if (!neg && (acc > lim)) begin
      len_cr_err = ST_TOO_LONG;
    end else begin
      len_cr_err = ST_OK;
    end
  end

  // error found by this byte
  always_comb begin
    err = ST_OK;
    unique case (phase)
      PH_TYPE: begin
        if (!(cls.is_plus || cls.is_minus || cls.is_colon || cls.is_dollar || cls.is_star)) begin
          err = ST_BAD_TYPE;
        end
      end
      PH_LINE: err = ST_OK;
      PH_LINE_LF, PH_INT_LF, PH_LEN_LF, PH_CNT_LF, PH_TRAIL_LF: begin
        if (!cls.is_lf) begin
          err = ST_BAD_TERM;
        end
      end
      PH_INT: begin
        if ((cls.is_plus || cls.is_minus) && !istart) begin
          err = ST_OK;
        end else if (cls.is_digit) begin
          err = int_ovf ? ST_BAD_INT : ST_OK;
        end else if (cls.is_cr) begin
          err = dseen ? ST_OK : ST_BAD_INT;
        end else begin
          err = ST_BAD_INT;
        end
      end
      PH_LEN, PH_CNT: begin
        if (cls.is_minus && !dseen && !neg) begin
          err = ST_OK;
        end else if (cls.is_digit) begin
          err = ST_OK;
        end else if (cls.is_cr) begin
          err = len_cr_err;
        end else begin
          err = ST_BAD_LEN;
        end
      end
      PH_DATA: err = ST_OK;
      PH_TRAIL_CR: begin
        if (!cls.is_cr) begin
          err = ST_BAD_TERM;
        end
      end
      PH_ELEM: begin
        if (!cls.is_dollar) begin
          err = ST_BAD_TYPE;
        end
      end
      PH_DONE: begin
        if (held > FT_INTEGER) begin
          err = ST_TRUNCATED;
        end
      end
      default: err = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    phase_adv = phase;
    if (active && (err == ST_OK)) begin
      unique case (phase)
        PH_TYPE: begin
          if (cls.is_plus || cls.is_minus) begin
            phase_adv = PH_LINE;
          end else if (cls.is_colon) begin
            phase_adv = PH_INT;
          end else if (cls.is_dollar) begin
            phase_adv = PH_LEN;
          end else begin
            phase_adv = PH_CNT;
          end
        end
        PH_LINE:     if (cls.is_cr) phase_adv = PH_LINE_LF;
        PH_LINE_LF:  phase_adv = PH_DONE;
        PH_INT:      if (cls.is_cr) phase_adv = PH_INT_LF;
        PH_INT_LF:   phase_adv = PH_DONE;
        PH_LEN:      if (cls.is_cr) phase_adv = PH_LEN_LF;
        PH_LEN_LF: begin
          if (neg) begin
            phase_adv = fin_phase;
          end else begin
            phase_adv = (acc[LENGTH_BITS-1:0] != '0) ? PH_DATA : PH_TRAIL_CR;
          end
        end
        PH_DATA:     if (bytes_rem == LENGTH_BITS'(1)) phase_adv = PH_TRAIL_CR;
        PH_TRAIL_CR: phase_adv = PH_TRAIL_LF;
        PH_TRAIL_LF: phase_adv = fin_phase;
        PH_CNT:      if (cls.is_cr) phase_adv = PH_CNT_LF;
        PH_CNT_LF: begin
          if (!neg && (acc[COUNT_BITS-1:0] != '0)) begin
            phase_adv = PH_ELEM;
          end else begin
            phase_adv = PH_DONE;
          end
        end
        PH_ELEM:     phase_adv = PH_LEN;
        PH_DONE:     phase_adv = PH_DONE;
        default:     phase_adv = PH_TYPE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    held_next      = held;
    acc_next       = acc;
    neg_next       = neg;
    dseen_next     = dseen;
    istart_next    = istart;
    bytes_rem_next = bytes_rem;
    elem_rem_next  = elem_rem;
    cur_elem_next  = cur_elem;
    sticky_next    = sticky;
    declared_next  = declared;
    res            = '0;
    status         = ST_OK;
    if (active) begin
      if (err != ST_OK) begin
        sticky_next = err;
      end else begin
        case (phase)
          PH_TYPE: begin
            acc_next    = '0;
            neg_next    = 1'b0;
            dseen_next  = 1'b0;
            istart_next = 1'b0;
            if (cls.is_minus) begin
              held_next = FT_ERROR;
            end else if (cls.is_plus) begin
              held_next = FT_SIMPLE;
            end else if (cls.is_colon) begin
              held_next = FT_INTEGER;
            end else if (cls.is_dollar) begin
              held_next = FT_BULK;
            end else begin
              held_next = FT_ARRAY;
            end
          end
          PH_LINE: begin
            if (!cls.is_cr) begin
              res.payload_valid = 1'b1;
              res.payload_byte  = cls.data;
            end
          end
          PH_INT: begin
            if ((cls.is_plus || cls.is_minus) && !istart) begin
              neg_next    = cls.is_minus;
              istart_next = 1'b1;
            end else if (cls.is_digit) begin
              istart_next = 1'b1;
              acc_next    = acc_mul;
              dseen_next  = 1'b1;
            end
          end
          PH_LEN, PH_CNT: begin
            if (cls.is_minus && !dseen && !neg) begin
              neg_next = 1'b1;
            end else if (cls.is_digit) begin
              acc_next   = (acc_mul > ceil_val) ? ceil_val + 1'b1 : acc_mul;
              dseen_next = 1'b1;
            end
          end
          PH_LEN_LF, PH_TRAIL_LF: begin
            if ((phase == PH_LEN_LF) && !neg) begin
              bytes_rem_next = acc[LENGTH_BITS-1:0];
            end else begin
              if (held == FT_BULK) begin
                held_next = (phase == PH_LEN_LF) ? FT_NULL : FT_BULK;
              end
              res.element_done = 1'b1;
              if (held == FT_ARRAY) begin
                res.element_index = cur_elem;
                cur_elem_next     = cur_elem + 1'b1;
                elem_rem_next     = elem_rem - 1'b1;
              end
            end
          end
          PH_DATA: begin
            res.payload_valid = 1'b1;
            res.payload_byte  = cls.data;
            if (held == FT_ARRAY) begin
              res.element_index = cur_elem;
            end
            bytes_rem_next = bytes_rem - 1'b1;
          end
          PH_CNT_LF: begin
            if (neg) begin
              held_next = FT_NULL;
            end else begin
              declared_next = acc[COUNT_BITS-1:0];
              elem_rem_next = acc[COUNT_BITS-1:0];
              cur_elem_next = '0;
            end
          end
          PH_ELEM: begin
            acc_next   = '0;
            neg_next   = 1'b0;
            dseen_next = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    if (cls.last) begin
      if (sticky_next != ST_OK) begin
        status = sticky_next;
      end else if (phase_adv != PH_DONE) begin
        status = ST_TRUNCATED;
      end
      res.frame_done   = 1'b1;
      res.frame_type   = held_next;
      res.frame_status = status;
      if ((held_next == FT_INTEGER) && (status == ST_OK)) begin
        res.integer_value = neg ? -acc : acc;
      end
      if ((held_next == FT_ARRAY) && (status == ST_OK)) begin
        res.array_count = declared_next;
      end
      held_next      = FT_SIMPLE;
      acc_next       = '0;
      neg_next       = 1'b0;
      dseen_next     = 1'b0;
      istart_next    = 1'b0;
      bytes_rem_next = '0;
      elem_rem_next  = '0;
      cur_elem_next  = '0;
      sticky_next    = ST_OK;
      declared_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TYPE;
      held      <= FT_SIMPLE;
      acc       <= '0;
      neg       <= 1'b0;
      dseen     <= 1'b0;
      istart    <= 1'b0;
      bytes_rem <= '0;
      elem_rem  <= '0;
      cur_elem  <= '0;
      sticky    <= ST_OK;
      declared  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase     <= cls.last ? PH_TYPE : phase_adv;
        held      <= held_next;
        acc       <= acc_next;
        neg       <= neg_next;
        dseen     <= dseen_next;
        istart    <= istart_next;
        bytes_rem <= bytes_rem_next;
        elem_rem  <= elem_rem_next;
        cur_elem  <= cur_elem_next;
        sticky    <= sticky_next;
        declared  <= declared_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.payload_valid = res_q.payload_valid;
  assign out_ch.payload_byte  = res_q.payload_byte;
  assign out_ch.element_index = res_q.element_index;
  assign out_ch.element_done  = res_q.element_done;
  assign out_ch.frame_done    = res_q.frame_done;
  assign out_ch.frame_type    = res_q.frame_type;
  assign out_ch.frame_status  = res_q.frame_status;
  assign out_ch.integer_value = res_q.integer_value;
  assign out_ch.array_count   = res_q.array_count;
endmodule
`default_nettype wire

### hdl/resp_frame_parser_top.sv
// Top level of the RESP frame parser: configuration registers and stage wiring.
//
// Usage:
//   in_ch carries one frame byte per item (data_byte, last_byte marks the end
//   of the buffer); out_ch returns exactly one result item per input item.
//   Throughput is one byte per cycle while out_ch is ready; the back stage does
//   one multiply-by-ten add and compare per byte. From input accept to result
//   valid, an item passes the classify register, a queue slot and the result
//   register, in that order.
//   When out_ch stalls, the result register holds, the queue fills, and
//   in_ch.ready drops once the front register and the queue are full.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 max bulk length, 1 max array count); write only while idle.
//   Reset (rst, synchronous, active high) empties the pipeline, returns the
//   parser to the type-byte phase and loads the default limits.
`default_nettype none
module resp_frame_parser_top (
  input  logic                                clk,
  input  logic                                rst,
  rfp_in_if.sink                              in_ch,
  rfp_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [rfp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rfp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import rfp_pkg::*;

  logic [LENGTH_BITS-1:0] max_len;
  logic [COUNT_BITS-1:0]  max_cnt;
  byte_class_t            f_item;
  logic                   f_valid;
  logic                   f_ready;
  byte_class_t            q_item;
  logic                   q_valid;
  logic                   q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_BULK_RESET;
      max_cnt <= MAX_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BULK:  max_len <= cfg_data[LENGTH_BITS-1:0];
        CFG_MAX_COUNT: max_cnt <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cls       (f_item),
    .cls_valid (f_valid),
    .cls_ready (f_ready)
  );

  rfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  rfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (q_item),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .max_len   (max_len),
    .max_cnt   (max_cnt),
    .out_ch    (out_ch)
  );

  a_verdict_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.frame_done) |->
      (out_ch.frame_type == FT_SIMPLE && out_ch.frame_status == ST_OK))
    else $error("verdict fields set on a result without frame_done");

  a_value_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.frame_status != ST_OK) |->
      (out_ch.integer_value == '0 && out_ch.array_count == '0))
    else $error("integer value or array count reported on a failed frame");

  a_done_not_payload: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.element_done) |-> !out_ch.payload_valid)
    else $error("element_done on a payload byte");
endmodule
`default_nettype wire

### dv/resp_frame_parser_checker.sv
// Checker of the RESP frame parser: predicts each result item and compares it.
module resp_frame_parser_checker (
  input  logic                               clk,
  input  logic                               rst,
  rfp_in_if                                  in_ch,
  rfp_out_if                                 out_ch,
  input  logic                               cfg_we,
  input  logic [rfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rfp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int unsigned                        fail_count,
  output int unsigned                        pending,
  output int unsigned                        frames_ok,
  output int unsigned                        frames_bad
);
  import rfp_pkg::*;

  logic [LENGTH_BITS-1:0] bulk_limit;
  logic [COUNT_BITS-1:0]  count_limit;

  phase_t                 phase;
  logic [2:0]             held_type;
  logic [VALUE_BITS-1:0]  acc;
  logic                   neg;
  logic                   digit_seen;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [COUNT_BITS-1:0]  elems_left;
  logic [INDEX_BITS-1:0]  cur_elem;
  logic [2:0]             sticky;
  logic [COUNT_BITS-1:0]  declared;

  result_t result_q[$];

  function void flag(logic [2:0] code);
    if (sticky == ST_OK) sticky = code;
  endfunction

  function void start_number();
    acc = '0;
    neg = 1'b0;
    digit_seen = 1'b0;
    bytes_left = '0;
  endfunction

  function void clear_parse();
    phase = PH_TYPE;
    held_type = FT_SIMPLE;
    start_number();
    elems_left = '0;
    cur_elem = '0;
    sticky = ST_OK;
    declared = '0;
  endfunction

  function bit take_len(logic [7:0] b, logic [63:0] lim);
    logic [63:0] ceil_v;
    if (b == CH_MINUS && !digit_seen && !neg) begin
      neg = 1'b1;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      ceil_v = neg ? 64'd1 : lim;
      acc = acc * 10 + 64'(b - CH_ZERO);
      if (acc > ceil_v) acc = ceil_v + 64'd1;
      digit_seen = 1'b1;
    end else if (b == CH_CR) begin
      if (!digit_seen) flag(ST_BAD_LEN);
      else if (neg && acc != 64'd1) flag(ST_BAD_LEN);
      else if (!neg && acc > lim) flag(ST_TOO_LONG);
      else return 1'b1;
    end else begin
      flag(ST_BAD_LEN);
    end
    return 1'b0;
  endfunction

  function void close_bulk(inout result_t r);
    r.element_done = 1'b1;
    if (held_type == FT_ARRAY) begin
      r.element_index = cur_elem;
      cur_elem = cur_elem + 1'b1;
      elems_left = elems_left - 1'b1;
      phase = (elems_left != '0) ? PH_ELEM : PH_DONE;
    end else begin
      phase = PH_DONE;
    end
  endfunction

  function result_t parse_byte(logic [7:0] b, logic last);
    result_t     r;
    logic [63:0] d;
    logic [63:0] lim;
    logic [2:0]  st;
    r = '0;
    if (sticky == ST_OK) begin
      case (phase)
        PH_TYPE: begin
          start_number();
          if (b == CH_PLUS || b == CH_MINUS) begin
            held_type = (b == CH_MINUS) ? FT_ERROR : FT_SIMPLE;
            phase = PH_LINE;
          end else if (b == CH_COLON) begin
            held_type = FT_INTEGER;
            phase = PH_INT;
          end else if (b == CH_DOLLAR) begin
            held_type = FT_BULK;
            phase = PH_LEN;
          end else if (b == CH_STAR) begin
            held_type = FT_ARRAY;
            phase = PH_CNT;
          end else flag(ST_BAD_TYPE);
        end
        PH_LINE: begin
          if (b == CH_CR) phase = PH_LINE_LF;
          else begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
          end
        end
        PH_LINE_LF, PH_INT_LF: begin
          if (b == CH_LF) phase = PH_DONE;
          else flag(ST_BAD_TERM);
        end
        PH_INT: begin
          if ((b == CH_MINUS || b == CH_PLUS) && bytes_left == '0) begin
            neg = (b == CH_MINUS);
            bytes_left = LENGTH_BITS'(1);
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            d = 64'(b - CH_ZERO);
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            bytes_left = LENGTH_BITS'(1);
            if (acc > (lim - d) / 10) flag(ST_BAD_INT);
            else begin
              acc = acc * 10 + d;
              digit_seen = 1'b1;
            end
          end else if (b == CH_CR) begin
            if (!digit_seen) flag(ST_BAD_INT);
            else phase = PH_INT_LF;
          end else flag(ST_BAD_INT);
        end
        PH_LEN: if (take_len(b, 64'(bulk_limit))) phase = PH_LEN_LF;
        PH_LEN_LF: begin
          if (b != CH_LF) flag(ST_BAD_TERM);
          else if (neg) begin
            if (held_type == FT_BULK) held_type = FT_NULL;
            close_bulk(r);
          end else begin
            bytes_left = acc[LENGTH_BITS-1:0];
            phase = (bytes_left != '0) ? PH_DATA : PH_TRAIL_CR;
          end
        end
        PH_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          if (held_type == FT_ARRAY) r.element_index = cur_elem;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) phase = PH_TRAIL_CR;
        end
        PH_TRAIL_CR: begin
          if (b == CH_CR) phase = PH_TRAIL_LF;
          else flag(ST_BAD_TERM);
        end
        PH_TRAIL_LF: begin
          if (b == CH_LF) close_bulk(r);
          else flag(ST_BAD_TERM);
        end
        PH_CNT: if (take_len(b, 64'(count_limit))) phase = PH_CNT_LF;
        PH_CNT_LF: begin
          if (b != CH_LF) flag(ST_BAD_TERM);
          else if (neg) begin
            held_type = FT_NULL;
            phase = PH_DONE;
          end else begin
            declared = acc[COUNT_BITS-1:0];
            elems_left = declared;
            cur_elem = '0;
            phase = (elems_left != '0) ? PH_ELEM : PH_DONE;
          end
        end
        PH_ELEM: begin
          if (b == CH_DOLLAR) begin
            start_number();
            phase = PH_LEN;
          end else flag(ST_BAD_TYPE);
        end
        default: if (held_type > FT_INTEGER) flag(ST_TRUNCATED);
      endcase
    end
    if (last) begin
      st = sticky;
      if (st == ST_OK && phase != PH_DONE) st = ST_TRUNCATED;
      r.frame_done = 1'b1;
      r.frame_type = held_type;
      r.frame_status = st;
      if (held_type == FT_INTEGER && st == ST_OK) r.integer_value = neg ? -acc : acc;
      if (held_type == FT_ARRAY && st == ST_OK) r.array_count = declared;
      clear_parse();
    end
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      clear_parse();
      bulk_limit = MAX_BULK_RESET;
      count_limit = MAX_COUNT_RESET;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_BULK) bulk_limit = cfg_data[LENGTH_BITS-1:0];
        else if (cfg_index == CFG_MAX_COUNT) count_limit = cfg_data[COUNT_BITS-1:0];
      end
      if (in_ch.valid && in_ch.ready)
        result_q.insert(result_q.size(), parse_byte(in_ch.data_byte, in_ch.last_byte));
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          report("result item with no input pending", 64'd1, 64'd0);
        end else begin
          e = result_q[0];
          result_q.delete(0);
          if (out_ch.payload_valid !== e.payload_valid)
            report("payload_valid", 64'(out_ch.payload_valid), 64'(e.payload_valid));
          if (out_ch.payload_byte !== e.payload_byte)
            report("payload_byte", 64'(out_ch.payload_byte), 64'(e.payload_byte));
          if (out_ch.element_index !== e.element_index)
            report("element_index", 64'(out_ch.element_index), 64'(e.element_index));
          if (out_ch.element_done !== e.element_done)
            report("element_done", 64'(out_ch.element_done), 64'(e.element_done));
          if (out_ch.frame_done !== e.frame_done)
            report("frame_done", 64'(out_ch.frame_done), 64'(e.frame_done));
          if (out_ch.frame_type !== e.frame_type)
            report("frame_type", 64'(out_ch.frame_type), 64'(e.frame_type));
          if (out_ch.frame_status !== e.frame_status)
            report("frame_status", 64'(out_ch.frame_status), 64'(e.frame_status));
          if (out_ch.integer_value !== e.integer_value)
            report("integer_value", out_ch.integer_value, e.integer_value);
          if (out_ch.array_count !== e.array_count)
            report("array_count", 64'(out_ch.array_count), 64'(e.array_count));
          if (e.frame_done) begin
            if (e.frame_status == ST_OK) frames_ok++;
            else frames_bad++;
          end
        end
      end
    end
    pending = result_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    frames_ok = 0;
    frames_bad = 0;
  end

endmodule

### dv/resp_frame_parser_top_tb.sv
// Testbench top of the RESP frame parser: clock, reset, frame stimulus and verdict.
module resp_frame_parser_top_tb;
  import rfp_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int unsigned fail_count, pending, frames_ok, frames_bad;
  int          bytes_sent;
  int          settings_used;
  int          stall_left;
  int          idle_cycles;
  bit          quiet;
  logic [7:0]  frame_q[$];

  rfp_in_if  in_ch ();
  rfp_out_if out_ch ();

  resp_frame_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  resp_frame_parser_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .frames_ok  (frames_ok),
    .frames_bad (frames_bad)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAIL resp_frame_parser_top");
        $finish;
      end
    end
  end

  task automatic add_byte(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic put_str(string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  task automatic put_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic put_bulk(int n);
    logic [7:0] b;
    put_str($sformatf("$%0d", n));
    put_crlf();
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      add_byte(b);
    end
    if (n >= 0) put_crlf();
  endtask

  task automatic put_line(logic [7:0] lead);
    logic [7:0] b;
    int         n;
    n = $urandom_range(0, 6);
    add_byte(lead);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      add_byte((b == CH_CR) ? CH_ZERO : b);
    end
    put_crlf();
    // trailing bytes after a line are dropped by the parser
    if ($urandom_range(0, 4) == 0) put_str("zz");
  endtask

  task automatic put_integer();
    logic signed [63:0] v;
    case ($urandom_range(0, 6))
      0: put_str(":9223372036854775807");
      1: put_str(":-9223372036854775808");
      2: put_str(":9223372036854775808");
      3: put_str(":-9223372036854775809");
      4: put_str($sformatf(":+%0d", $urandom_range(0, 999)));
      default: begin
        v = {$urandom, $urandom};
        v = v >>> $urandom_range(0, 63);
        put_str($sformatf(":%0d", v));
      end
    endcase
    put_crlf();
  endtask

  task automatic put_array();
    int n;
    n = $urandom_range(0, 4);
    if ($urandom_range(0, 7) == 0) begin
      put_str("*-1");
      put_crlf();
    end else begin
      put_str($sformatf("*%0d", n));
      put_crlf();
      for (int i = 0; i < n; i++) begin
        put_bulk($urandom_range(0, 5) == 0 ? -1 : int'($urandom_range(0, 5)));
      end
    end
  endtask

  task automatic put_good_frame();
    case ($urandom_range(0, 9))
      0: put_line(CH_PLUS);
      1: put_line(CH_MINUS);
      2, 3: put_integer();
      4, 5: put_bulk($urandom_range(0, 9) == 0 ? int'($urandom_range(7, 40))
                                               : int'($urandom_range(0, 7)) - 1);
      6, 7, 8: put_array();
      default: begin
        put_str($urandom_range(0, 1) ? "$99999999999" : "*2097151");
        put_crlf();
      end
    endcase
  endtask

  task automatic put_bad_frame();
    int k;
    case ($urandom_range(0, 5))
      0: begin
        put_good_frame();
        k = $urandom_range(0, frame_q.size() - 1);
        frame_q[k] = 8'($urandom);
      end
      1: begin
        put_good_frame();
        k = $urandom_range(1, frame_q.size());
        while (frame_q.size() > k) frame_q.delete(frame_q.size() - 1);
      end
      2: begin
        put_good_frame();
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
      3: repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      4: begin
        case ($urandom_range(0, 4))
          0: put_str("$-2");
          1: put_str("$1a");
          2: put_str("$");
          3: put_str("$--1");
          default: put_str("*-0");
        endcase
        put_crlf();
      end
      default: begin
        put_str("*2");
        put_crlf();
        put_str(":1");
        put_crlf();
      end
    endcase
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic send_str(string s);
    put_str(s);
    send_frame();
  endtask

  task automatic set_limits(int unsigned bulk, int unsigned count);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_BULK;
    cfg_data <= CFG_DATA_BITS'(bulk);
    @(posedge clk);
    cfg_index <= CFG_MAX_COUNT;
    cfg_data <= CFG_DATA_BITS'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    bytes_sent = 0;
    settings_used = 0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_str("+a\r\n");
    send_str(":-5\r\n");
    send_str("$-1\r\n");
    send_str("*-1\r\n");
    send_str("!");
    send_str("$0\r\n\r\n");

    while (bytes_sent < 1100) begin
      case (bytes_sent / 140)
        1: if (settings_used != 1) set_limits(0, 0);
        2: if (settings_used != 2) set_limits(5, 3);
        3: if (settings_used != 3) set_limits(536870912, 1048576);
        4: if (settings_used != 4) set_limits(2, 1);
        5: if (settings_used != 5) set_limits(40, 4);
        default: ;
      endcase
      if (bytes_sent > 900) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) put_bad_frame();
      else put_good_frame();
      send_frame();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d bytes under %0d limit settings", bytes_sent, settings_used + 1);
    $display("frames checked: %0d clean, %0d with an error status", frames_ok, frames_bad);
    if (fail_count == 0) begin
      $display("PASS resp_frame_parser_top");
    end else begin
      $display("FAIL resp_frame_parser_top");
    end
    $finish;
  end

endmodule

### resp_frame_parser_top.f
hdl/rfp_pkg.sv
hdl/rfp_if.sv
hdl/rfp_front.sv
hdl/rfp_queue.sv
hdl/rfp_back.sv
hdl/resp_frame_parser_top.sv
dv/resp_frame_parser_checker.sv
dv/resp_frame_parser_top_tb.sv
